FILE: hdl/midi_track_event_parser_unit_assert.svh
// Assertion macros for the MIDI track parser top level.
// No dependencies; included by midi_track_event_parser_unit.sv.
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MTEP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mtep_pkg.sv
// Shared types and constants of the MIDI track event parser.
// No dependencies; used by all mtep modules and the top level.
package mtep_pkg;

    // 'M' 'T' 'r' 'k', index 0 is the first byte
    localparam logic [3:0][7:0] CHUNK_TAG = {8'h6B, 8'h72, 8'h54, 8'h4D};

    localparam logic [7:0] BYTE_META    = 8'hFF;
    localparam logic [7:0] BYTE_SYS_MIN = 8'hF0;

    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;

    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;

    localparam logic [2:0] EV_NOTE      = 3'd0;
    localparam logic [2:0] EV_TEMPO     = 3'd1;
    localparam logic [2:0] EV_TIMESIG   = 3'd2;
    localparam logic [2:0] EV_EOT       = 3'd3;
    localparam logic [2:0] EV_ERROR     = 3'd4;

    localparam logic [1:0] ERR_BAD_ID   = 2'd0;
    localparam logic [1:0] ERR_LONG_VLQ = 2'd1;
    localparam logic [1:0] ERR_SYSTEM   = 2'd2;

    localparam int unsigned OUT_DATA_W  = 128;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [27:0] delta_ticks;
        logic [31:0] absolute_ticks;
        logic [3:0]  channel;
        logic [6:0]  note_number;
        logic [6:0]  velocity;
        logic        note_is_on;
        logic [23:0] tempo_usec;
        logic [7:0]  sig_numerator;
        logic [7:0]  sig_denom_exp;
        logic [1:0]  error_code;
    } event_rec_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

FILE: hdl/midi_track_event_parser_unit.sv
// Usage:
// Parses one standard MIDI file track chunk, one byte per slave transaction.
// Slave side: s_tdata carries the raw byte, s_tuser[0] marks the first byte of
// a new chunk and clears all track state before that byte is parsed.
// Master side: one transaction per note, tempo, time signature, end of track
// or error; m_tuser holds the event kind, m_tdata the event fields.
// Throughput: one byte per cycle while the queue is not full; each byte is a single
// phase update of the front-end parser, with no iteration.
// Path: an event caused by an accepted byte is written into the queue, then
// loaded into the output register, which presents it on the master side.
// Stall: the queue (QUEUE_DEPTH events) absorbs master back-pressure; when it
// fills, s_tready drops until the output stage takes an event.
// After an error or end of track, bytes are accepted and dropped until the
// next chunk start.
// Reset (rst_n low, asynchronous): parser returns to the chunk header phase
// with zero track time, the queue empties and m_tvalid drops.
`include "midi_track_event_parser_unit_assert.svh"

module midi_track_event_parser_unit
    import mtep_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] track_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [27:0] delta_ticks, [59:28] absolute_ticks, [63:60] channel,
    // [70:64] note_number, [77:71] velocity, [78] note_is_on,
    // [102:79] tempo_usec, [110:103] sig_numerator, [118:111] sig_denom_exp,
    // [120:119] error_code, [127:121] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]            m_tuser    // [2:0] event_kind
);

    q_stat_t    q_stat;
    logic       q_push;
    logic       q_pop;
    event_rec_t q_in_rec;
    event_rec_t q_out_rec;

    // front end: handshake on the slave side and the parse itself
    mtep_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_start (s_tuser[0]),
        .q_stat   (q_stat),
        .push     (q_push),
        .push_rec (q_in_rec)
    );

    // decouples parsing from master-side stalls
    mtep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_in_rec),
        .pop      (q_pop),
        .pop_rec  (q_out_rec),
        .q_stat   (q_stat)
    );

    // back end: registered master side
    mtep_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_rec  (q_out_rec),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // no event may be pushed into a full queue
    `MTEP_ASSERT_SAME(a_no_push_full, q_push, !q_stat.full, "event pushed into full queue")
    // a pop must find data and a free or draining output register
    `MTEP_ASSERT_SAME(a_pop_legal, q_pop, q_stat.not_empty && (!m_tvalid || m_tready), "illegal pop")
    // a full queue that is not drained stays full and blocks the slave side
    `MTEP_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full && !s_tready, "full lost")
    // error events carry no timing
    `MTEP_ASSERT_SAME(a_err_no_time, m_tvalid && (m_tuser == EV_ERROR), m_tdata[59:0] == '0, "err time")

endmodule

FILE: hdl/mtep_front.sv
// Front end: byte-level track chunk parser, one byte per cycle while the queue
// has room. Depends on mtep_pkg; pushes finished events into mtep_queue.
module mtep_front
    import mtep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    input  q_stat_t    q_stat,
    output logic       push,
    output event_rec_t push_rec
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_MLEN,
        PH_MDATA,
        PH_HALT
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [2:0]  hcnt_reg, hcnt_next, cur_hcnt;
    logic [7:0]  rstat_reg, rstat_next, cur_rstat;
    logic [27:0] vacc_reg, vacc_next, cur_vacc;
    logic [1:0]  vcnt_reg, vcnt_next, cur_vcnt;
    logic [27:0] hdel_reg, hdel_next, cur_hdel;
    logic [7:0]  mtype_reg, mtype_next, cur_mtype;
    logic [27:0] mrem_reg, mrem_next, cur_mrem;
    logic [7:0]  fdb_reg, fdb_next, cur_fdb;
    logic [23:0] tacc_reg, tacc_next, cur_tacc;
    logic [7:0]  nhold_reg, nhold_next, cur_nhold;
    logic [31:0] ttime_reg, ttime_next, cur_ttime;

    logic        accept;
    logic [27:0] vlq_val;
    logic        vlq_done;
    logic        vlq_long;
    logic [32:0] time_sum;
    logic [31:0] time_sat;
    logic        fin_chan;
    logic        fin_meta;
    logic        res;
    event_rec_t  rec;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // track_start clears everything before the byte is looked at
    assign cur_phase = in_start ? PH_HEADER : phase_reg;
    assign cur_hcnt  = in_start ? '0 : hcnt_reg;
    assign cur_rstat = in_start ? '0 : rstat_reg;
    assign cur_vacc  = in_start ? '0 : vacc_reg;
    assign cur_vcnt  = in_start ? '0 : vcnt_reg;
    assign cur_hdel  = in_start ? '0 : hdel_reg;
    assign cur_mtype = in_start ? '0 : mtype_reg;
    assign cur_mrem  = in_start ? '0 : mrem_reg;
    assign cur_fdb   = in_start ? '0 : fdb_reg;
    assign cur_tacc  = in_start ? '0 : tacc_reg;
    assign cur_nhold = in_start ? '0 : nhold_reg;
    assign cur_ttime = in_start ? '0 : ttime_reg;

    // variable-length quantity step
    assign vlq_val  = {cur_vacc[20:0], in_byte[6:0]};
    assign vlq_done = !in_byte[7];
    assign vlq_long = in_byte[7] && (cur_vcnt == 2'd3);

    // saturating track time
    assign time_sum = {1'b0, cur_ttime} + {5'd0, cur_hdel};
    assign time_sat = time_sum[32] ? '1 : time_sum[31:0];

    always_comb
    begin
        phase_next = cur_phase;
        hcnt_next  = cur_hcnt;
        rstat_next = cur_rstat;
        vacc_next  = cur_vacc;
        vcnt_next  = cur_vcnt;
        hdel_next  = cur_hdel;
        mtype_next = cur_mtype;
        mrem_next  = cur_mrem;
        fdb_next   = cur_fdb;
        tacc_next  = cur_tacc;
        nhold_next = cur_nhold;
        ttime_next = cur_ttime;
        fin_chan   = 1'b0;
        fin_meta   = 1'b0;
        res        = 1'b0;
        rec        = '0;

        case (cur_phase)
            PH_HEADER:
            begin
                if (!cur_hcnt[2] && (in_byte != CHUNK_TAG[cur_hcnt[1:0]]))
                begin
                    res            = 1'b1;
                    rec.event_kind = EV_ERROR;
                    rec.error_code = ERR_BAD_ID;
                    phase_next     = PH_HALT;
                end
                else if (cur_hcnt == 3'd7)
                begin
                    hcnt_next  = '0;
                    vacc_next  = '0;
                    vcnt_next  = '0;
                    phase_next = PH_DELTA;
                end
                else
                begin
                    hcnt_next = cur_hcnt + 3'd1;
                end
            end
            PH_DELTA:
            begin
                vacc_next = vlq_val;
                if (vlq_done)
                begin
                    vcnt_next  = '0;
                    hdel_next  = vlq_val;
                    vacc_next  = '0;
                    phase_next = PH_STATUS;
                end
                else if (vlq_long)
                begin
                    vcnt_next      = '0;
                    res            = 1'b1;
                    rec.event_kind = EV_ERROR;
                    rec.error_code = ERR_LONG_VLQ;
                    phase_next     = PH_HALT;
                end
                else
                begin
                    vcnt_next = cur_vcnt + 2'd1;
                end
            end
            PH_STATUS:
            begin
                if (in_byte == BYTE_META)
                begin
                    phase_next = PH_MTYPE;
                end
                else if (in_byte >= BYTE_SYS_MIN)
                begin
                    res            = 1'b1;
                    rec.event_kind = EV_ERROR;
                    rec.error_code = ERR_SYSTEM;
                    phase_next     = PH_HALT;
                end
                else if (in_byte[7])
                begin
                    rstat_next = in_byte;
                    phase_next = PH_DATA1;
                end
                else
                begin
                    // data byte under running status
                    fdb_next = in_byte;
                    if (!cur_rstat[7] || cur_rstat[7:4] == HI_PROGRAM
                        || cur_rstat[7:4] == HI_PRESSURE)
                        fin_chan = 1'b1;
                    else
                        phase_next = PH_DATA2;
                end
            end
            PH_DATA1:
            begin
                fdb_next = in_byte;
                if (!cur_rstat[7] || cur_rstat[7:4] == HI_PROGRAM
                    || cur_rstat[7:4] == HI_PRESSURE)
                    fin_chan = 1'b1;
                else
                    phase_next = PH_DATA2;
            end
            PH_DATA2:
            begin
                fin_chan = 1'b1;
            end
            PH_MTYPE:
            begin
                mtype_next = in_byte;
                vacc_next  = '0;
                vcnt_next  = '0;
                phase_next = PH_MLEN;
            end
            PH_MLEN:
            begin
                vacc_next = vlq_val;
                if (vlq_done)
                begin
                    vcnt_next = '0;
                    mrem_next = vlq_val;
                    vacc_next = '0;
                    if (cur_mtype == META_EOT)
                    begin
                        ttime_next         = time_sat;
                        res                = 1'b1;
                        rec.event_kind     = EV_EOT;
                        rec.delta_ticks    = cur_hdel;
                        rec.absolute_ticks = time_sat;
                        phase_next         = PH_HALT;
                    end
                    else
                    begin
                        // only well-formed tempo and time signature metas are kept
                        if (!((cur_mtype == META_TEMPO && vlq_val == 28'd3)
                            || (cur_mtype == META_TIMESIG && vlq_val == 28'd4)))
                            mtype_next = '0;
                        tacc_next = '0;
                        if (vlq_val == '0)
                            fin_meta = 1'b1;
                        else
                            phase_next = PH_MDATA;
                    end
                end
                else if (vlq_long)
                begin
                    vcnt_next      = '0;
                    res            = 1'b1;
                    rec.event_kind = EV_ERROR;
                    rec.error_code = ERR_LONG_VLQ;
                    phase_next     = PH_HALT;
                end
                else
                begin
                    vcnt_next = cur_vcnt + 2'd1;
                end
            end
            PH_MDATA:
            begin
                if (cur_mtype == META_TEMPO)
                    tacc_next = {cur_tacc[15:0], in_byte};
                else if (cur_mtype == META_TIMESIG)
                begin
                    if (cur_mrem == 28'd4)
                        nhold_next = in_byte;
                    else if (cur_mrem == 28'd3)
                        fdb_next = in_byte;
                end
                mrem_next = cur_mrem - 28'd1;
                if (cur_mrem == 28'd1)
                    fin_meta = 1'b1;
            end
            default:
            begin
                // halted until the next track start
            end
        endcase

        if (fin_chan)
        begin
            phase_next = PH_DELTA;
            ttime_next = time_sat;
            if (cur_rstat[7:4] == HI_NOTE_OFF || cur_rstat[7:4] == HI_NOTE_ON)
            begin
                res                = 1'b1;
                rec.event_kind     = EV_NOTE;
                rec.delta_ticks    = cur_hdel;
                rec.absolute_ticks = time_sat;
                rec.channel        = cur_rstat[3:0];
                rec.note_number    = fdb_next[6:0];
                rec.velocity       = in_byte[6:0];
                rec.note_is_on     = (cur_rstat[7:4] == HI_NOTE_ON) && (in_byte[6:0] != '0);
            end
        end

        if (fin_meta)
        begin
            phase_next = PH_DELTA;
            ttime_next = time_sat;
            if (mtype_next == META_TEMPO)
            begin
                res                = 1'b1;
                rec.event_kind     = EV_TEMPO;
                rec.delta_ticks    = cur_hdel;
                rec.absolute_ticks = time_sat;
                rec.tempo_usec     = tacc_next;
            end
            else if (mtype_next == META_TIMESIG)
            begin
                res                = 1'b1;
                rec.event_kind     = EV_TIMESIG;
                rec.delta_ticks    = cur_hdel;
                rec.absolute_ticks = time_sat;
                rec.sig_numerator  = nhold_next;
                rec.sig_denom_exp  = fdb_next;
            end
        end
    end

    assign push     = accept && res;
    assign push_rec = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= '0;
            rstat_reg <= '0;
            vacc_reg  <= '0;
            vcnt_reg  <= '0;
            hdel_reg  <= '0;
            mtype_reg <= '0;
            mrem_reg  <= '0;
            fdb_reg   <= '0;
            tacc_reg  <= '0;
            nhold_reg <= '0;
            ttime_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            rstat_reg <= rstat_next;
            vacc_reg  <= vacc_next;
            vcnt_reg  <= vcnt_next;
            hdel_reg  <= hdel_next;
            mtype_reg <= mtype_next;
            mrem_reg  <= mrem_next;
            fdb_reg   <= fdb_next;
            tacc_reg  <= tacc_next;
            nhold_reg <= nhold_next;
            ttime_reg <= ttime_next;
        end
    end

endmodule

FILE: hdl/mtep_queue.sv
// Small event queue between parser front end and output stage.
// Depends on mtep_pkg for the event record and status types.
module mtep_queue
    import mtep_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  event_rec_t push_rec,
    input  logic       pop,
    output event_rec_t pop_rec,
    output q_stat_t    q_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    event_rec_t       slots [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    assign q_stat.full      = (count_reg == CW'(DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign pop_rec          = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_rec;
    end

endmodule

FILE: hdl/mtep_back.sv
// Back end: output register that drains the event queue onto the master side.
// Depends on mtep_pkg for the event record and status types.
module mtep_back
    import mtep_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  q_stat_t               q_stat,
    input  event_rec_t            pop_rec,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]            m_tuser
);

    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [2:0]            kind_reg;
    logic [OUT_DATA_W-1:0] data_next;

    // reload whenever the register is empty or being drained
    assign pop = q_stat.not_empty && (!valid_reg || m_tready);

    assign data_next = {7'd0,
                        pop_rec.error_code,
                        pop_rec.sig_denom_exp,
                        pop_rec.sig_numerator,
                        pop_rec.tempo_usec,
                        pop_rec.note_is_on,
                        pop_rec.velocity,
                        pop_rec.note_number,
                        pop_rec.channel,
                        pop_rec.absolute_ticks,
                        pop_rec.delta_ticks};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            kind_reg <= pop_rec.event_kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

endmodule
